FILE: design/lmi_ad_pkg.sv
// ----------------------------------------------------------------------------
// lmi_ad_pkg
// Shared types and constants of the Annex D LMI frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lmi_ad_pkg;

  // Header and element codes
  localparam logic [7:0] PROT_DISC     = 8'h08;
  localparam logic [7:0] CALL_REF      = 8'h00;
  localparam logic [7:0] LOCK_SHIFT    = 8'h95;
  localparam logic [7:0] MT_ENQUIRY    = 8'h75;
  localparam logic [7:0] MT_STATUS     = 8'h7D;
  localparam logic [7:0] IE_REPORT     = 8'h01;
  localparam logic [7:0] IE_LINK       = 8'h03;
  localparam logic [7:0] IE_PVC        = 8'h07;
  localparam logic [7:0] PVC_LEN_SHORT = 8'h03;
  localparam logic [7:0] PVC_LEN_LONG  = 8'h05;

  // Report types
  localparam logic [7:0] RT_LINK_ONLY  = 8'h01;
  localparam logic [7:0] RT_ASYNC      = 8'h02;
  localparam logic [7:0] RT_REPOLL     = 8'h04;

  // Verdict codes
  localparam logic [1:0] V_REJECT = 2'd0;
  localparam logic [1:0] V_REPLY  = 2'd1;
  localparam logic [1:0] V_NONE   = 2'd2;
  localparam logic [1:0] V_REPOLL = 2'd3;

  // Result kinds
  localparam logic KIND_PVC     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_SEND_SEQ = 2'd0;
  localparam logic [1:0] REG_LINK_DOWN    = 2'd1;
  localparam logic [1:0] REG_LAST_FULL    = 2'd2;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [22:0] pvc_dlci;
    logic [7:0]  pvc_status;
    logic        pvc_active;
    logic        out_of_order;
    logic [1:0]  verdict;
    logic        seq_accepted;
    logic        loopback_suspect;
    logic [7:0]  peer_send_seq;
    logic [7:0]  peer_recv_seq;
    logic [7:0]  rpt_type;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [7:0] own_send_seq;
    logic       link_down;
    logic       last_poll_was_full;
  } cfg_t;

  // Up to two results per byte: a PVC report, then the verdict
  typedef struct packed {
    logic      pvc_valid;
    out_word_t pvc_word;
    logic      vd_valid;
    out_word_t vd_word;
  } push_t;

endpackage

`default_nettype wire

FILE: design/lmi_ad_parser.sv
// ----------------------------------------------------------------------------
// lmi_ad_parser
// Input register and per-byte frame parse; builds PVC reports and verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module lmi_ad_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire lmi_ad_pkg::in_word_t in_word,
  input  wire lmi_ad_pkg::cfg_t   cfg,
  output logic                    busy,
  output lmi_ad_pkg::push_t       push
);
  import lmi_ad_pkg::*;

  localparam logic [2:0] PH_PD    = 3'd0;
  localparam logic [2:0] PH_CR    = 3'd1;
  localparam logic [2:0] PH_MT    = 3'd2;
  localparam logic [2:0] PH_SHIFT = 3'd3;
  localparam logic [2:0] PH_ID    = 3'd4;
  localparam logic [2:0] PH_LEN   = 3'd5;
  localparam logic [2:0] PH_VAL   = 3'd6;
  localparam logic [2:0] PH_SKIP  = 3'd7;

  logic        s1_valid_r;
  in_word_t    s1_word_r;

  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [7:0]  elem_id_r, elem_id_nxt;
  logic [7:0]  elem_len_r, elem_len_nxt;
  logic [7:0]  elem_off_r, elem_off_nxt;
  logic [7:0]  val_r [4];
  logic [7:0]  send_seq_r, send_seq_nxt;
  logic [7:0]  recv_seq_r, recv_seq_nxt;
  logic [22:0] largest_r, largest_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;
  logic [7:0]  rpt_type_r, rpt_type_nxt;

  logic [7:0]  b;
  logic [7:0]  off_inc;
  logic        val_we;
  logic [22:0] dlci;
  logic        pvc_hit;
  logic        seq_ok;

  // Stage 1: the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
    if (in_fire) begin
      s1_word_r <= in_word;
    end
  end

  assign busy = s1_valid_r;
  assign b    = s1_word_r.rx_byte;
  assign off_inc = elem_off_r + 8'd1;

  always_comb begin
    byte_count_nxt = (byte_count_r < 3'd4) ? byte_count_r + 3'd1 : byte_count_r;
    phase_nxt      = phase_r;
    mtype_nxt      = mtype_r;
    elem_id_nxt    = elem_id_r;
    elem_len_nxt   = elem_len_r;
    elem_off_nxt   = elem_off_r;
    send_seq_nxt   = send_seq_r;
    recv_seq_nxt   = recv_seq_r;
    largest_nxt    = largest_r;
    hdr_bad_nxt    = hdr_bad_r;
    rpt_type_nxt   = rpt_type_r;
    val_we         = 1'b0;
    pvc_hit        = 1'b0;
    dlci           = '0;

    unique case (phase_r)
      PH_PD: begin
        if (b != PROT_DISC) begin
          hdr_bad_nxt = 1'b1;
          phase_nxt   = PH_SKIP;
        end else begin
          phase_nxt = PH_CR;
        end
      end
      PH_CR: begin
        if (b != CALL_REF) begin
          hdr_bad_nxt = 1'b1;
          phase_nxt   = PH_SKIP;
        end else begin
          phase_nxt = PH_MT;
        end
      end
      PH_MT: begin
        mtype_nxt = b;
        phase_nxt = PH_SHIFT;
      end
      PH_SHIFT: begin
        if (b == LOCK_SHIFT) begin
          phase_nxt = PH_ID;
        end else begin
          elem_id_nxt = b;
          phase_nxt   = PH_LEN;
        end
      end
      PH_ID: begin
        elem_id_nxt = b;
        phase_nxt   = PH_LEN;
      end
      PH_LEN: begin
        elem_len_nxt = b;
        elem_off_nxt = '0;
        phase_nxt    = (b == 8'd0) ? PH_ID : PH_VAL;
      end
      PH_VAL: begin
        val_we = (elem_off_r < 8'd4);
        if (elem_id_r == IE_REPORT && elem_off_r == 8'd0) begin
          rpt_type_nxt = b;
        end else if (elem_id_r == IE_LINK && elem_off_r == 8'd1) begin
          send_seq_nxt = val_r[0];
          recv_seq_nxt = b;
        end else if (elem_id_r == IE_PVC) begin
          // DLCI bits sit under masks 0x3F / 0x78 / 0x7F / 0x7E of the octets
          if (elem_len_r == PVC_LEN_SHORT && elem_off_r == 8'd2) begin
            pvc_hit = 1'b1;
            dlci    = {13'd0, val_r[0][5:0], val_r[1][6:3]};
          end else if (elem_len_r == PVC_LEN_LONG && elem_off_r == 8'd4) begin
            pvc_hit = 1'b1;
            dlci    = {val_r[0][5:0], val_r[1][6:3], val_r[2][6:0], val_r[3][6:1]};
          end
        end
        if (pvc_hit && dlci > largest_r) begin
          largest_nxt = dlci;
        end
        elem_off_nxt = off_inc;
        if (off_inc >= elem_len_r) begin
          phase_nxt = PH_ID;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
  end

  // Verdict, taken on the state as updated by the final byte
  assign seq_ok = (recv_seq_nxt == cfg.own_send_seq) ||
                  (cfg.link_down && recv_seq_nxt == 8'd0);

  always_comb begin
    push = '0;
    push.pvc_valid                  = s1_valid_r && pvc_hit;
    push.pvc_word.result_kind       = KIND_PVC;
    push.pvc_word.pvc_dlci          = dlci;
    push.pvc_word.pvc_status        = b;
    push.pvc_word.pvc_active        = b[1];
    push.pvc_word.out_of_order      = (largest_r != 23'd0) && (dlci <= largest_r);
    push.pvc_word.last_of_run       = !s1_word_r.end_of_frame;

    push.vd_valid                   = s1_valid_r && s1_word_r.end_of_frame;
    push.vd_word.result_kind        = KIND_VERDICT;
    push.vd_word.verdict            = V_REJECT;
    push.vd_word.peer_send_seq      = send_seq_nxt;
    push.vd_word.peer_recv_seq      = recv_seq_nxt;
    push.vd_word.rpt_type           = rpt_type_nxt;
    push.vd_word.last_of_run        = 1'b1;
    if (byte_count_nxt >= 3'd4 && !hdr_bad_nxt) begin
      if (mtype_nxt == MT_ENQUIRY) begin
        push.vd_word.verdict = V_REPLY;
      end else if (mtype_nxt == MT_STATUS) begin
        push.vd_word.verdict = V_NONE;
        if (rpt_type_nxt != RT_ASYNC &&
            !(cfg.last_poll_was_full && rpt_type_nxt == RT_LINK_ONLY) && seq_ok) begin
          push.vd_word.seq_accepted     = 1'b1;
          push.vd_word.loopback_suspect = (send_seq_nxt != 8'd0) &&
                                          (send_seq_nxt == cfg.own_send_seq);
          if (rpt_type_nxt == RT_REPOLL) begin
            push.vd_word.verdict = V_REPOLL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      phase_r      <= PH_PD;
      mtype_r      <= '0;
      elem_id_r    <= '0;
      elem_len_r   <= '0;
      elem_off_r   <= '0;
      send_seq_r   <= '0;
      recv_seq_r   <= '0;
      largest_r    <= '0;
      hdr_bad_r    <= 1'b0;
      rpt_type_r   <= '0;
    end else if (s1_valid_r) begin
      rpt_type_r <= rpt_type_nxt;
      if (s1_word_r.end_of_frame) begin
        byte_count_r <= '0;
        phase_r      <= PH_PD;
        mtype_r      <= '0;
        elem_id_r    <= '0;
        elem_len_r   <= '0;
        elem_off_r   <= '0;
        send_seq_r   <= '0;
        recv_seq_r   <= '0;
        largest_r    <= '0;
        hdr_bad_r    <= 1'b0;
      end else begin
        byte_count_r <= byte_count_nxt;
        phase_r      <= phase_nxt;
        mtype_r      <= mtype_nxt;
        elem_id_r    <= elem_id_nxt;
        elem_len_r   <= elem_len_nxt;
        elem_off_r   <= elem_off_nxt;
        send_seq_r   <= send_seq_nxt;
        recv_seq_r   <= recv_seq_nxt;
        largest_r    <= largest_nxt;
        hdr_bad_r    <= hdr_bad_nxt;
      end
    end
  end

  // Element value bytes; only the first four are ever read back
  always_ff @(posedge clk) begin
    if (s1_valid_r && val_we) begin
      val_r[elem_off_r[1:0]] <= b;
    end
  end

endmodule

`default_nettype wire

FILE: design/lmi_ad_fifo.sv
// ----------------------------------------------------------------------------
// lmi_ad_fifo
// Result queue; takes up to two words per cycle, gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lmi_ad_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lmi_ad_pkg::push_t    push,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lmi_ad_pkg::out_word_t     out_data,
  output logic [lmi_ad_pkg::FIFO_AW:0] count
);
  import lmi_ad_pkg::*;

  out_word_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  logic               first_v, second_v, pop;
  out_word_t          first_word;
  logic [FIFO_AW:0]   n_push;

  assign first_v    = push.pvc_valid || push.vd_valid;
  assign second_v   = push.pvc_valid && push.vd_valid;
  assign first_word = push.pvc_valid ? push.pvc_word : push.vd_word;
  assign n_push     = (FIFO_AW+1)'(first_v) + (FIFO_AW+1)'(second_v);
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (first_v) begin
      mem_r[wr_ptr_r] <= first_word;
    end
    if (second_v) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.vd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push[FIFO_AW-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + n_push - (FIFO_AW+1)'(pop);
    end
  end

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

`default_nettype wire

FILE: design/lmi_annex_d_frame_parser.sv
// ----------------------------------------------------------------------------
// lmi_annex_d_frame_parser
// Frame relay LMI (Annex D) receive parser, one frame byte per word.
//
// Input words carry one frame byte from the protocol discriminator on, with
// end_of_frame on the final byte. Each byte gives zero, one or two result
// words: a PVC status report when a PVC element completes, and the frame
// verdict on the final byte (the report first when both occur).
// Path: a byte is held in the input register, then the parse logic writes
// its result words into the result queue, from which the output port reads.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver keeps up; the output port drains one word per cycle, so
// a byte with two results costs the receiver one extra word to drain.
// in_ready is low in reset and otherwise high while the queue fill plus two
// words for a byte in the input register is at most four of the eight queue
// words, so a stalled receiver fills the queue and then holds off the
// sender; nothing is dropped.
// Reset clears the parse state, report type and queue and sets the
// configuration to own_send_seq 0, link_down 1, last_poll_was_full 0.
// Configuration must be written only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module lmi_annex_d_frame_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lmi_ad_pkg::in_word_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lmi_ad_pkg::out_word_t      out_data,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);
  import lmi_ad_pkg::*;

  cfg_t             cfg_r;
  logic             in_fire;
  logic             busy;
  push_t            push;
  logic [FIFO_AW:0] fifo_count;
  logic [FIFO_AW:0] committed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_send_seq       <= 8'd0;
      cfg_r.link_down          <= 1'b1;
      cfg_r.last_poll_was_full <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_SEND_SEQ: cfg_r.own_send_seq       <= cfg_data;
        REG_LINK_DOWN:    cfg_r.link_down          <= cfg_data[0];
        REG_LAST_FULL:    cfg_r.last_poll_was_full <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Words already promised to the queue: its fill plus two for the byte in flight
  assign committed = fifo_count + (busy ? (FIFO_AW+1)'(2) : '0);
  assign in_ready  = rst_n && (committed <= (FIFO_AW+1)'(FIFO_DEPTH - 4));
  assign in_fire   = in_valid && in_ready;

  lmi_ad_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_word (in_data),
    .cfg     (cfg_r),
    .busy    (busy),
    .push    (push)
  );

  lmi_ad_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pvc_only_with_word: assert property (@(posedge clk) disable iff (!rst_n)
    push.pvc_valid |-> $past(in_fire))
    else $error("PVC report without an accepted byte");

  a_pvc_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_PVC |->
      out_data.verdict == V_REJECT && !out_data.seq_accepted &&
      out_data.rpt_type == 8'd0)
    else $error("PVC report carries verdict fields");

  a_accept_implies_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.seq_accepted |->
      out_data.verdict == V_NONE || out_data.verdict == V_REPOLL)
    else $error("accepted sequence with wrong verdict");

endmodule

`default_nettype wire

FILE: sim/lmi_annex_d_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// lmi_annex_d_frame_parser_tb
// Self-checking bench for the Annex D LMI frame parser: a short scripted
// run of frames, then random frames under several register settings; two scripted verdicts are
// checked against fixed words, every other result word against a byte-level parse model kept here.
// ----------------------------------------------------------------------------
module lmi_annex_d_frame_parser_tb;
  import lmi_ad_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int PHASE_BYTES = 225;
  localparam int SCRIPT_LEN  = 23;

  typedef enum logic [2:0] {
    AT_DISC, AT_CREF, AT_MTYPE, AT_SHIFT, AT_ID, AT_LEN, AT_VALUE, AT_DISCARD
  } parse_step_e;

  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    logic       typed;
    out_word_t  want;
  } step_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  lmi_annex_d_frame_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register shadows, at their reset values
  logic [7:0] cfg_own  = 8'h00;
  logic       cfg_down = 1'b1;
  logic       cfg_full = 1'b0;

  // Parse model state, at its reset values
  parse_step_e step       = AT_DISC;
  logic [2:0]  seen_bytes = '0;
  logic [7:0]  frame_mtype = '0;
  logic [7:0]  ie_id      = '0;
  logic [7:0]  ie_len     = '0;
  logic [7:0]  ie_off     = '0;
  logic [7:0]  ie_bytes [5];
  logic [7:0]  f_send     = '0;
  logic [7:0]  f_recv     = '0;
  logic [22:0] top_dlci   = '0;
  logic        hdr_bad    = 1'b0;
  logic [7:0]  rpt_type   = '0;
  logic [7:0]  enq_send   = '0;
  logic [7:0]  enq_recv   = '0;
  logic [7:0]  peer_seq   = '0;
  logic        status_seen = 1'b0;

  out_word_t made [2];
  int        made_n;
  out_word_t due_words [$];

  int  mismatch_count = 0;
  int  stuck_cycles   = 0;
  int  gap_odds       = 0;
  bit  quiet          = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // One frame byte through the parse model; results land in made[]
  task automatic lmi_parse_byte(input logic [7:0] b, input logic eof);
    logic [7:0]  off;
    logic [22:0] dlci;
    logic        has_pvc;
    logic [1:0]  v;
    out_word_t   w;
    made_n  = 0;
    has_pvc = 1'b0;
    dlci    = '0;
    if (seen_bytes < 3'd4) seen_bytes++;
    case (step)
      AT_DISC: begin
        if (b != PROT_DISC) begin
          hdr_bad = 1'b1;
          step = AT_DISCARD;
        end else step = AT_CREF;
      end
      AT_CREF: begin
        if (b != CALL_REF) begin
          hdr_bad = 1'b1;
          step = AT_DISCARD;
        end else step = AT_MTYPE;
      end
      AT_MTYPE: begin
        frame_mtype = b;
        step = AT_SHIFT;
      end
      AT_SHIFT: begin
        if (b == LOCK_SHIFT) step = AT_ID;
        else begin
          ie_id = b;
          step = AT_LEN;
        end
      end
      AT_ID: begin
        ie_id = b;
        step = AT_LEN;
      end
      AT_LEN: begin
        ie_len = b;
        ie_off = '0;
        step = (b == 8'h00) ? AT_ID : AT_VALUE;
      end
      AT_VALUE: begin
        off = ie_off;
        if (off < 8'd5) ie_bytes[off[2:0]] = b;
        if (ie_id == IE_REPORT && off == 8'd0) rpt_type = b;
        else if (ie_id == IE_LINK && off == 8'd1) begin
          f_send = ie_bytes[0];
          f_recv = b;
        end else if (ie_id == IE_PVC && ie_len == PVC_LEN_SHORT && off == 8'd2) begin
          dlci = {13'd0, ie_bytes[0][5:0], ie_bytes[1][6:3]};
          has_pvc = 1'b1;
        end else if (ie_id == IE_PVC && ie_len == PVC_LEN_LONG && off == 8'd4) begin
          dlci = {ie_bytes[0][5:0], ie_bytes[1][6:3], ie_bytes[2][6:0], ie_bytes[3][6:1]};
          has_pvc = 1'b1;
        end
        if (has_pvc) begin
          w = '0;
          w.result_kind  = KIND_PVC;
          w.pvc_dlci     = dlci;
          w.pvc_status   = b;
          w.pvc_active   = b[1];
          w.out_of_order = (top_dlci != '0) && (dlci <= top_dlci);
          if (dlci > top_dlci) top_dlci = dlci;
          made[made_n] = w;
          made_n++;
        end
        ie_off = off + 8'd1;
        if (ie_off >= ie_len) step = AT_ID;
      end
      default: ;
    endcase

    if (eof) begin
      w = '0;
      w.result_kind = KIND_VERDICT;
      v = V_REJECT;
      if (seen_bytes >= 3'd4 && !hdr_bad) begin
        if (frame_mtype == MT_ENQUIRY) begin
          enq_send = f_send;
          enq_recv = f_recv;
          v = V_REPLY;
        end else if (frame_mtype == MT_STATUS) begin
          v = V_NONE;
          // async reports and link-only answers to a full poll are never accepted
          if (rpt_type != RT_ASYNC && !(cfg_full && rpt_type == RT_LINK_ONLY) &&
              (f_recv == cfg_own || (cfg_down && f_recv == 8'h00))) begin
            w.seq_accepted     = 1'b1;
            w.loopback_suspect = (f_send != 8'h00) && (f_send == cfg_own);
            peer_seq    = f_send;
            status_seen = 1'b1;
            if (rpt_type == RT_REPOLL) v = V_REPOLL;
          end
        end
      end
      w.verdict       = v;
      w.peer_send_seq = f_send;
      w.peer_recv_seq = f_recv;
      w.rpt_type      = rpt_type;
      made[made_n] = w;
      made_n++;
      seen_bytes  = '0;
      step        = AT_DISC;
      frame_mtype = '0;
      ie_id       = '0;
      ie_len      = '0;
      ie_off      = '0;
      f_send      = '0;
      f_recv      = '0;
      top_dlci    = '0;
      hdr_bad     = 1'b0;
    end
    if (made_n > 0) made[made_n-1].last_of_run = 1'b1;
  endtask

  function automatic step_row_t plain(input logic [7:0] b, input logic eof);
    step_row_t r;
    r = '0;
    r.b = b;
    r.eof = eof;
    return r;
  endfunction

  function automatic step_row_t closing(input logic [7:0] b, input out_word_t w);
    step_row_t r;
    r = '0;
    r.b = b;
    r.eof = 1'b1;
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic out_word_t verdict_word(input logic [1:0] v, input logic [7:0] rt);
    out_word_t w;
    w = '0;
    w.result_kind = KIND_VERDICT;
    w.verdict     = v;
    w.rpt_type    = rt;
    w.last_of_run = 1'b1;
    return w;
  endfunction

  // Entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                           input out_word_t want);
    int gap;
    int i;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, end_of_frame: eof};
    do @(posedge clk); while (!in_ready);
    lmi_parse_byte(b, eof);
    if (typed) due_words.push_back(want);
    else for (i = 0; i < made_n; i++) due_words.push_back(made[i]);
    @(negedge clk);
  endtask

  // Hold the sender until every due word is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(input logic [7:0] own, input logic down, input logic full);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_SEND_SEQ;
    cfg_data  <= own;
    @(negedge clk);
    cfg_index <= REG_LINK_DOWN;
    cfg_data  <= {7'd0, down};
    @(negedge clk);
    cfg_index <= REG_LAST_FULL;
    cfg_data  <= {7'd0, full};
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_own  = own;
    cfg_down = down;
    cfg_full = full;
  endtask

  // Receiver: stretches of steady ready, and stretches with stall bursts
  initial begin : drain_side
    int stall_left;
    int stretch;
    int odds;
    out_ready  = 1'b0;
    stall_left = 0;
    stretch    = 0;
    odds       = 0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: odds = 0;
          1: odds = 3;
          default: odds = 10;
        endcase
      end
      stretch--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && odds != 0 && $urandom_range(1, odds) == 1) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) flag_mismatch("result word with nothing due");
      else begin
        want = due_words.pop_front();
        if (out_data !== want)
          flag_mismatch($sformatf("result word got %h, want %h", out_data, want));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", STUCK_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : stimulus
    step_row_t  script [SCRIPT_LEN];
    logic [7:0] frame_bytes [$];
    logic [7:0] own;
    logic       down;
    logic       full;
    int         phase_no;
    int         sent;
    int         i;
    int         k;
    int         n;
    int         len;
    bit         zero_dlci;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_OWN_SEND_SEQ;
    cfg_data  = 8'h00;

    script = '{
      // short frame, good header
      plain(8'h08, 1'b0), plain(8'h00, 1'b0), closing(8'h7D, verdict_word(V_REJECT, 8'h00)),
      // bad discriminator
      plain(8'hFF, 1'b0), plain(8'h00, 1'b0), plain(8'h75, 1'b0),
      closing(8'h00, verdict_word(V_REJECT, 8'h00)),
      // STATUS: shift, repoll report type, link integrity, 10-bit PVC ending on eof
      plain(8'h08, 1'b0), plain(8'h00, 1'b0), plain(8'h7D, 1'b0), plain(8'h95, 1'b0),
      plain(8'h01, 1'b0), plain(8'h01, 1'b0), plain(8'h04, 1'b0),
      plain(8'h03, 1'b0), plain(8'h02, 1'b0), plain(8'h05, 1'b0), plain(8'h00, 1'b0),
      plain(8'h07, 1'b0), plain(8'h03, 1'b0), plain(8'h3F, 1'b0), plain(8'h7F, 1'b0),
      plain(8'hFF, 1'b1)
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_odds = 4;
    for (i = 0; i < SCRIPT_LEN; i++)
      send_byte(script[i].b, script[i].eof, script[i].typed, script[i].want);

    for (phase_no = 0; phase_no < 6; phase_no++) begin
      settle();
      case (phase_no)
        0: begin own = 8'h00; down = 1'b1; full = 1'b0; end
        1: begin own = 8'hFF; down = 1'b0; full = 1'b1; end
        2: begin own = 8'($urandom_range(1, 254)); down = 1'b1; full = 1'b1; end
        3: begin own = 8'($urandom_range(0, 255)); down = 1'b0; full = 1'b0; end
        4: begin own = 8'($urandom_range(0, 255)); down = 1'b0; full = 1'b1; end
        default: begin own = 8'h01; down = 1'b1; full = 1'b0; end
      endcase
      load_settings(own, down, full);
      quiet = (phase_no == 5);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if (!quiet && $urandom_range(0, 24) == 0) settle();
        frame_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
          // line noise
          n = $urandom_range(1, 8);
          repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1) frame_bytes[0] = PROT_DISC;
        end else begin
          frame_bytes.push_back(PROT_DISC);
          frame_bytes.push_back(CALL_REF);
          case ($urandom_range(0, 5))
            0, 1, 2: frame_bytes.push_back(MT_STATUS);
            3, 4:    frame_bytes.push_back(MT_ENQUIRY);
            default: frame_bytes.push_back(8'($urandom_range(0, 255)));
          endcase
          if ($urandom_range(0, 1) == 1) frame_bytes.push_back(LOCK_SHIFT);
          n = $urandom_range(0, 5);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0, 1: begin
                frame_bytes.push_back(IE_REPORT);
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 1;
                frame_bytes.push_back(8'(len));
                if (len > 0) begin
                  case ($urandom_range(0, 5))
                    0:       frame_bytes.push_back(RT_LINK_ONLY);
                    1:       frame_bytes.push_back(RT_ASYNC);
                    2, 3:    frame_bytes.push_back(RT_REPOLL);
                    4:       frame_bytes.push_back(8'h00);
                    default: frame_bytes.push_back(8'($urandom_range(0, 255)));
                  endcase
                end
                if (len > 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
              end
              2, 3: begin
                frame_bytes.push_back(IE_LINK);
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 2;
                frame_bytes.push_back(8'(len));
                case ($urandom_range(0, 3))
                  0:       frame_bytes.push_back(own);
                  1:       frame_bytes.push_back(8'h00);
                  default: frame_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
                if (len > 1) begin
                  case ($urandom_range(0, 4))
                    0, 1, 2: frame_bytes.push_back(own);
                    3:       frame_bytes.push_back(8'h00);
                    default: frame_bytes.push_back(8'($urandom_range(0, 255)));
                  endcase
                end
                if (len > 2) frame_bytes.push_back(8'($urandom_range(0, 255)));
              end
              4, 5, 6, 7: begin
                frame_bytes.push_back(IE_PVC);
                k = $urandom_range(0, 9);
                len = (k < 5) ? 3 : (k < 9) ? 5 : $urandom_range(0, 7);
                frame_bytes.push_back(8'(len));
                zero_dlci = ($urandom_range(0, 7) == 0);
                for (k = 0; k < len; k++)
                  frame_bytes.push_back((zero_dlci && k < len - 1) ? 8'h00
                                        : 8'($urandom_range(0, 255)));
              end
              8: begin
                frame_bytes.push_back(8'($urandom_range(0, 255)));
                len = $urandom_range(0, 4);
                frame_bytes.push_back(8'(len));
                repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
              end
              default: begin
                // length extremes; a long one runs past the frame end
                frame_bytes.push_back(8'($urandom_range(0, 255)));
                frame_bytes.push_back(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
                repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
              end
            endcase
          end
          if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
          end
        end
        if (quiet) gap_odds = 0;
        else begin
          case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 4;
            default: gap_odds = 12;
          endcase
        end
        for (i = 0; i < frame_bytes.size(); i++)
          send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
        sent += frame_bytes.size();
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
